// ===== hdl/tcpq_pkg.sv =====
// tcpq_pkg: shared types, codes and sizes for the two-class priority queue
// used by tcpq_ctrl, tcpq_datapath and two_class_priority_queue_top
package tcpq_pkg;

    localparam int URGENT_DEPTH = 16;
    localparam int NORMAL_DEPTH = 16;
    localparam int ID_WIDTH     = 32;

    // address, occupancy and tail-sum widths of each fifo
    localparam int U_AW = (URGENT_DEPTH > 1) ? $clog2(URGENT_DEPTH) : 1;
    localparam int U_CW = $clog2(URGENT_DEPTH + 1);
    localparam int U_PW = U_AW + 1;
    localparam int N_AW = (NORMAL_DEPTH > 1) ? $clog2(NORMAL_DEPTH) : 1;
    localparam int N_CW = $clog2(NORMAL_DEPTH + 1);
    localparam int N_PW = N_AW + 1;

    typedef logic [ID_WIDTH-1:0] id_t;

    typedef enum logic {
        FUNC_PLACE = 1'b0,
        FUNC_SERVE = 1'b1
    } func_t;

    typedef enum logic [1:0] {
        ST_PLACED = 2'd0,
        ST_SERVED = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LOAD
    } state_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic can_load;
    } dp_stat_t;

endpackage

// ===== hdl/two_class_priority_queue_top.sv =====
// Two-class strict-priority queue of identifiers. A place request (func 0)
// pushes order_id into the urgent or normal fifo chosen by is_urgent and
// answers placed, or full when that fifo holds its depth; a serve request
// (func 1) pops the urgent fifo while it holds entries, else the normal one,
// else answers empty. Each request gives exactly one result word. A request
// occupies the controller through its capture, fifo update (with registered
// head read) and result load states; the result load waits while an earlier
// result word is still held by rsp_stall. The next request is accepted only
// after the result load, and may be accepted while a result word still waits
// on rsp_stall.
// depends on tcpq_pkg, tcpq_ctrl, tcpq_datapath
module two_class_priority_queue_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic        func,
    input  logic [31:0] order_id,
    input  logic        is_urgent,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [1:0]  status,
    output logic [31:0] served_id,
    output logic        served_urgent
);
    import tcpq_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    tcpq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    tcpq_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .func          (func),
        .order_id      (order_id),
        .is_urgent     (is_urgent),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .status        (status),
        .served_id     (served_id),
        .served_urgent (served_urgent)
    );

endmodule

// ===== hdl/tcpq_ctrl.sv =====
// tcpq_ctrl: request sequencer for the two-class priority queue
// depends on tcpq_pkg; drives tcpq_datapath through ctrl_cmd_t
module tcpq_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  tcpq_pkg::dp_stat_t   stat,
    output tcpq_pkg::ctrl_cmd_t  cmd
);
    import tcpq_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (stat.can_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_stall = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                req_stall   = 1'b0;
                cmd.capture = req_valid;
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            S_LOAD:
            begin
                cmd.load = stat.can_load;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== hdl/tcpq_datapath.sv =====
// tcpq_datapath: urgent and normal fifo storage, pointers, result register
// depends on tcpq_pkg; sequenced by tcpq_ctrl
module tcpq_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tcpq_pkg::ctrl_cmd_t  cmd,
    output tcpq_pkg::dp_stat_t   stat,
    input  logic                 func,
    input  logic [31:0]          order_id,
    input  logic                 is_urgent,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output logic [1:0]           status,
    output logic [31:0]          served_id,
    output logic                 served_urgent
);
    import tcpq_pkg::*;

    // captured request
    func_t       req_func_reg;
    id_t         req_id_reg;
    logic        req_urg_reg;

    // fifo storage and pointers
    id_t         u_mem [URGENT_DEPTH];
    id_t         n_mem [NORMAL_DEPTH];
    id_t         u_rd_reg;
    id_t         n_rd_reg;
    logic [U_AW-1:0] u_head_reg;
    logic [U_AW-1:0] u_head_next;
    logic [U_CW-1:0] u_count_reg;
    logic [U_CW-1:0] u_count_next;
    logic [N_AW-1:0] n_head_reg;
    logic [N_AW-1:0] n_head_next;
    logic [N_CW-1:0] n_count_reg;
    logic [N_CW-1:0] n_count_next;

    // per-request decision
    logic        push_u;
    logic        push_n;
    logic        pop_u;
    logic        pop_n;
    logic [U_PW-1:0] u_sum;
    logic [N_PW-1:0] n_sum;
    logic [U_AW-1:0] u_wptr;
    logic [N_AW-1:0] n_wptr;
    status_t     res_status_next;
    status_t     res_status_reg;
    logic        res_urg_reg;

    // result word
    logic        rsp_valid_reg;
    logic        rsp_valid_next;
    status_t     rsp_status_reg;
    logic [31:0] rsp_id_reg;
    logic        rsp_urg_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_func_reg <= func_t'(func);
            req_id_reg   <= ID_WIDTH'(order_id);
            req_urg_reg  <= is_urgent;
        end
    end

    always_comb
    begin
        push_u = cmd.exec && (req_func_reg == FUNC_PLACE) && req_urg_reg
                 && (u_count_reg != U_CW'(URGENT_DEPTH));
        push_n = cmd.exec && (req_func_reg == FUNC_PLACE) && !req_urg_reg
                 && (n_count_reg != N_CW'(NORMAL_DEPTH));
        pop_u  = cmd.exec && (req_func_reg == FUNC_SERVE) && (u_count_reg != '0);
        pop_n  = cmd.exec && (req_func_reg == FUNC_SERVE) && (u_count_reg == '0)
                 && (n_count_reg != '0);

        if (req_func_reg == FUNC_PLACE)
        begin
            res_status_next = (push_u || push_n) ? ST_PLACED : ST_FULL;
        end
        else
        begin
            res_status_next = (pop_u || pop_n) ? ST_SERVED : ST_EMPTY;
        end
    end

    // tail position is head plus occupancy, wrapped once
    always_comb
    begin
        u_sum = U_PW'(u_head_reg) + U_PW'(u_count_reg);
        if (u_sum >= U_PW'(URGENT_DEPTH))
        begin
            u_wptr = U_AW'(u_sum - U_PW'(URGENT_DEPTH));
        end
        else
        begin
            u_wptr = U_AW'(u_sum);
        end

        n_sum = N_PW'(n_head_reg) + N_PW'(n_count_reg);
        if (n_sum >= N_PW'(NORMAL_DEPTH))
        begin
            n_wptr = N_AW'(n_sum - N_PW'(NORMAL_DEPTH));
        end
        else
        begin
            n_wptr = N_AW'(n_sum);
        end
    end

    always_comb
    begin
        u_head_next  = u_head_reg;
        u_count_next = u_count_reg;
        n_head_next  = n_head_reg;
        n_count_next = n_count_reg;
        if (push_u)
        begin
            u_count_next = u_count_reg + 1'b1;
        end
        if (pop_u)
        begin
            u_count_next = u_count_reg - 1'b1;
            u_head_next  = (u_head_reg == U_AW'(URGENT_DEPTH - 1)) ? '0
                           : u_head_reg + 1'b1;
        end
        if (push_n)
        begin
            n_count_next = n_count_reg + 1'b1;
        end
        if (pop_n)
        begin
            n_count_next = n_count_reg - 1'b1;
            n_head_next  = (n_head_reg == N_AW'(NORMAL_DEPTH - 1)) ? '0
                           : n_head_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            u_head_reg  <= '0;
            u_count_reg <= '0;
            n_head_reg  <= '0;
            n_count_reg <= '0;
        end
        else
        begin
            u_head_reg  <= u_head_next;
            u_count_reg <= u_count_next;
            n_head_reg  <= n_head_next;
            n_count_reg <= n_count_next;
        end
    end

    // storage: one write at the tail, registered read at the head
    always_ff @(posedge clk)
    begin
        if (push_u)
        begin
            u_mem[u_wptr] <= req_id_reg;
        end
        if (cmd.exec)
        begin
            u_rd_reg <= u_mem[u_head_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_n)
        begin
            n_mem[n_wptr] <= req_id_reg;
        end
        if (cmd.exec)
        begin
            n_rd_reg <= n_mem[n_head_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            res_status_reg <= res_status_next;
            res_urg_reg    <= pop_u;
        end
    end

    // result register
    assign stat.can_load = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rsp_status_reg <= res_status_reg;
            rsp_urg_reg    <= res_urg_reg;
            if (res_status_reg == ST_SERVED)
            begin
                rsp_id_reg <= res_urg_reg ? 32'(u_rd_reg) : 32'(n_rd_reg);
            end
            else
            begin
                rsp_id_reg <= '0;
            end
        end
    end

    assign rsp_valid     = rsp_valid_reg;
    assign status        = rsp_status_reg;
    assign served_id     = rsp_id_reg;
    assign served_urgent = rsp_urg_reg;

`ifndef NO_ASSERTIONS
    a_u_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        u_count_reg <= U_CW'(URGENT_DEPTH))
        else $error("urgent occupancy above depth");

    a_n_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        n_count_reg <= N_CW'(NORMAL_DEPTH))
        else $error("normal occupancy above depth");

    a_urgent_first: assert property (@(posedge clk) disable iff (!rst_n)
        pop_n |-> (u_count_reg == '0))
        else $error("normal fifo served while urgent holds entries");

    a_pop_u_count: assert property (@(posedge clk) disable iff (!rst_n)
        pop_u |=> (u_count_reg == $past(u_count_reg) - 1'b1))
        else $error("urgent occupancy not decremented on serve");

    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && (rsp_status_reg != ST_SERVED))
        |-> ((rsp_id_reg == '0) && !rsp_urg_reg))
        else $error("non-serve result carries an identifier");
`endif

endmodule

// ===== verif/two_class_priority_queue_top_tb.sv =====
`timescale 1ns / 1ps
// two_class_priority_queue_top_tb: self-checking bench for the urgent/normal priority queue
// directed table then random place/serve episodes, every result word checked in order
// depends on tcpq_pkg and two_class_priority_queue_top
module two_class_priority_queue_top_tb;

    import tcpq_pkg::*;

    typedef struct {
        status_t     status;
        logic [31:0] id;
        logic        urgent;
    } answer_t;

    typedef struct {
        func_t   f;
        id_t     id;
        logic    u;
        int      reps;
        logic    pinned;
        answer_t ans;
    } plan_row_t;

    localparam int RANDOM_WORDS = 850;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    logic        func;
    logic [31:0] order_id;
    logic        is_urgent;
    logic        rsp_valid;
    logic        rsp_stall;
    logic [1:0]  status;
    logic [31:0] served_id;
    logic        served_urgent;

    logic        pin_en;
    answer_t     pin_ans;
    logic        quiet;

    id_t             urg_mem [URGENT_DEPTH];
    logic [U_AW-1:0] urg_rd;
    logic [U_CW-1:0] urg_cnt;
    id_t             norm_mem [NORMAL_DEPTH];
    logic [N_AW-1:0] norm_rd;
    logic [N_CW-1:0] norm_cnt;

    answer_t   pending_answers [$];
    plan_row_t plan [$];
    int        err_cnt;

    two_class_priority_queue_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .func          (func),
        .order_id      (order_id),
        .is_urgent     (is_urgent),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .status        (status),
        .served_id     (served_id),
        .served_urgent (served_urgent)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        if (err_cnt < 200)
            $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        err_cnt++;
    endtask

    function automatic answer_t priority_outcome(input func_t f, input id_t id, input logic u);
        answer_t         a;
        logic [U_AW-1:0] u_slot;
        logic [N_AW-1:0] n_slot;
        a = '{ST_PLACED, 32'd0, 1'b0};
        if (f == FUNC_PLACE)
        begin
            if (u)
            begin
                if (urg_cnt == U_CW'(URGENT_DEPTH))
                    a.status = ST_FULL;
                else
                begin
                    u_slot = U_AW'((int'(urg_rd) + int'(urg_cnt)) % URGENT_DEPTH);
                    urg_mem[u_slot] = id;
                    urg_cnt = urg_cnt + 1'b1;
                end
            end
            else
            begin
                if (norm_cnt == N_CW'(NORMAL_DEPTH))
                    a.status = ST_FULL;
                else
                begin
                    n_slot = N_AW'((int'(norm_rd) + int'(norm_cnt)) % NORMAL_DEPTH);
                    norm_mem[n_slot] = id;
                    norm_cnt = norm_cnt + 1'b1;
                end
            end
        end
        else if (urg_cnt != '0)
        begin
            a.status = ST_SERVED;
            a.id     = 32'(urg_mem[urg_rd]);
            a.urgent = 1'b1;
            urg_rd   = U_AW'((int'(urg_rd) + 1) % URGENT_DEPTH);
            urg_cnt  = urg_cnt - 1'b1;
        end
        else if (norm_cnt != '0)
        begin
            a.status = ST_SERVED;
            a.id     = 32'(norm_mem[norm_rd]);
            norm_rd  = N_AW'((int'(norm_rd) + 1) % NORMAL_DEPTH);
            norm_cnt = norm_cnt - 1'b1;
        end
        else
            a.status = ST_EMPTY;
        return a;
    endfunction

    always @(posedge clk)
    begin
        answer_t want;
        answer_t pred;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_answers.size() == 0)
                report("unexpected word", 64'(status), 64'd0);
            else
            begin
                want = pending_answers.pop_front();
                if (status != want.status)
                    report("status", 64'(status), 64'(want.status));
                if (served_id != want.id)
                    report("served_id", 64'(served_id), 64'(want.id));
                if (served_urgent != want.urgent)
                    report("served_urgent", 64'(served_urgent), 64'(want.urgent));
            end
        end
        if (rst_n && req_valid && !req_stall)
        begin
            pred = priority_outcome(func_t'(func), id_t'(order_id), is_urgent);
            pending_answers.push_back(pin_en ? pin_ans : pred);
        end
    end

    initial
    begin
        int n;
        rsp_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            n = quiet ? 0 : $urandom_range(0, 8);
            repeat (n)
            begin
                rsp_stall <= 1'b1;
                @(posedge clk);
            end
            rsp_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(rsp_valid && !rsp_stall));
        end
    end

    task automatic send_word(input func_t f, input id_t id, input logic u,
                             input logic pe, input answer_t pa);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        func      <= f;
        order_id  <= 32'(id);
        is_urgent <= u;
        pin_en    <= pe;
        pin_ans   <= pa;
        do
            @(posedge clk);
        while (!(req_valid && !req_stall));
    endtask

    task automatic settle();
        int waited;
        waited = 0;
        req_valid <= 1'b0;
        do
        begin
            @(posedge clk);
            waited++;
        end
        while (pending_answers.size() != 0 && waited < 2000);
    endtask

    task automatic add_row(input func_t f, input id_t id, input logic u, input int reps,
                           input logic pinned, input answer_t ans);
        plan_row_t r;
        r = '{f, id, u, reps, pinned, ans};
        plan.push_back(r);
    endtask

    initial
    begin
        answer_t none;
        int      sent;
        int      len;
        int      mode;
        int      bias;
        int      place_pct;
        func_t   f;
        id_t     id;
        none      = '{ST_PLACED, 32'd0, 1'b0};
        err_cnt   = 0;
        quiet     = 1'b0;
        urg_rd    = '0;
        urg_cnt   = '0;
        norm_rd   = '0;
        norm_cnt  = '0;
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        func      <= FUNC_PLACE;
        order_id  <= 32'd0;
        is_urgent <= 1'b0;
        pin_en    <= 1'b0;
        pin_ans   <= none;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_row(FUNC_SERVE, 32'h1234_5678, 1'b1, 1, 1'b1, '{ST_EMPTY, 32'd0, 1'b0});
        add_row(FUNC_PLACE, 32'hFFFF_FFFF, 1'b1, 1, 1'b1, '{ST_PLACED, 32'd0, 1'b0});
        add_row(FUNC_PLACE, 32'h0000_0000, 1'b0, 1, 1'b1, '{ST_PLACED, 32'd0, 1'b0});
        add_row(FUNC_SERVE, 32'hFFFF_FFFF, 1'b0, 1, 1'b1,
                '{ST_SERVED, 32'hFFFF_FFFF, 1'b1});
        add_row(FUNC_SERVE, 32'h0000_0000, 1'b1, 1, 1'b1, '{ST_SERVED, 32'd0, 1'b0});
        add_row(FUNC_SERVE, 32'hDEAD_BEEF, 1'b0, 1, 1'b1, '{ST_EMPTY, 32'd0, 1'b0});
        add_row(FUNC_PLACE, 32'h8000_0000, 1'b1, URGENT_DEPTH, 1'b0, none);
        add_row(FUNC_PLACE, 32'h7FFF_FFFF, 1'b1, 1, 1'b1, '{ST_FULL, 32'd0, 1'b0});
        add_row(FUNC_PLACE, 32'hA5A5_A5A5, 1'b0, 1, 1'b0, none);
        add_row(FUNC_SERVE, 32'h5A5A_5A5A, 1'b0, 1, 1'b0, none);

        foreach (plan[i])
            for (int k = 0; k < plan[i].reps; k++)
                send_word(plan[i].f, plan[i].id + id_t'(k), plan[i].u,
                          plan[i].pinned, plan[i].ans);

        settle();

        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            len   = $urandom_range(10, 60);
            mode  = $urandom_range(0, 2);
            bias  = $urandom_range(0, 100);
            quiet = ($urandom_range(0, 3) == 0);
            place_pct = (mode == 0) ? 80 : (mode == 1) ? 20 : 50;
            for (int k = 0; k < len && sent < RANDOM_WORDS; k++)
            begin
                f = ($urandom_range(0, 99) < place_pct) ? FUNC_PLACE : FUNC_SERVE;
                case ($urandom_range(0, 15))
                    0:       id = '0;
                    1:       id = '1;
                    default: id = id_t'($urandom);
                endcase
                send_word(f, id, ($urandom_range(0, 99) < bias), 1'b0, none);
                sent++;
            end
            if ($urandom_range(0, 4) == 0)
                settle();
        end
        quiet = 1'b0;

        settle();
        repeat (10) @(posedge clk);
        if (pending_answers.size() != 0)
            report("words never answered", 64'(pending_answers.size()), 64'd0);
        if (err_cnt == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
